// ===== hw/rtl/tsfs_pkg.sv =====
// Package: shared constants, types and helper functions of the telemetry slot framer.
`timescale 1ns / 1ps
`default_nettype none
package tsfs_pkg;

    localparam int MAX_SLOTS    = 10;
    localparam int VALUE_BYTES  = 4;
    localparam int DICT_ENTRIES = 5;
    localparam int NUM_SLOTS    = (DICT_ENTRIES < MAX_SLOTS) ? DICT_ENTRIES : MAX_SLOTS;
    localparam int SLOT_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int KW           = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;
    localparam int NUM_CLASSES  = 3;
    localparam int NUM_REGS     = 4;
    localparam int REG_IDX_W    = $clog2(NUM_REGS);

    typedef logic [31:0]          word_t;
    typedef logic [1:0]           class_t;
    typedef logic [SLOT_W-1:0]    slot_idx_t;
    typedef logic [NUM_SLOTS-1:0] slot_mask_t;
    typedef logic [NUM_CLASSES-1:0] class_mask_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam class_t CLASS_SLOW  = 2'd0;
    localparam class_t CLASS_FAST  = 2'd1;
    localparam class_t CLASS_VFAST = 2'd2;

    localparam reg_idx_t REG_PERIOD_SLOW  = 2'd0;
    localparam reg_idx_t REG_PERIOD_FAST  = 2'd1;
    localparam reg_idx_t REG_PERIOD_VFAST = 2'd2;
    localparam reg_idx_t REG_CLASS_ENABLE = 2'd3;

    localparam word_t       RST_PERIOD_SLOW  = 32'd100000;
    localparam word_t       RST_PERIOD_FAST  = 32'd10000;
    localparam word_t       RST_PERIOD_VFAST = 32'd1000;
    localparam class_mask_t RST_CLASS_ENABLE = 3'd4;

    localparam logic [7:0] SOF_BYTE  = 8'hAA;
    localparam logic [7:0] EOF_BYTE  = 8'h55;
    localparam word_t      WRAP_STEP = 32'h0001_0000;

    localparam class_t ID_CLASS [DICT_ENTRIES] =
        '{CLASS_SLOW, CLASS_FAST, CLASS_VFAST, CLASS_VFAST, CLASS_FAST};

    // scheduler to framer: classes due on this tick
    typedef struct packed {
        logic        start;
        class_mask_t mask;
    } frame_req_t;

    function automatic slot_mask_t class_members(input class_t cls);
        slot_mask_t m;
        m = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            m[i] = (ID_CLASS[i] == cls);
        end
        return m;
    endfunction

    function automatic slot_idx_t first_slot(input slot_mask_t m);
        slot_idx_t r;
        r = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (m[i]) r = SLOT_W'(i);
        end
        return r;
    endfunction

    function automatic class_t first_class(input class_mask_t m);
        class_t r;
        r = CLASS_SLOW;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (m[i]) r = 2'(i);
        end
        return r;
    endfunction

    function automatic logic [7:0] len_byte(input slot_mask_t m);
        logic [7:0] s;
        s = 8'd0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (m[i]) s = s + 8'(1 + VALUE_BYTES);
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tsfs_ifs.sv =====
// Interfaces: request channel and frame byte channel.
`timescale 1ns / 1ps
`default_nettype none
interface tsfs_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  var_id;
    logic [31:0] var_value;
    logic [15:0] timer_count;

    modport source (output valid, req_type, var_id, var_value, timer_count, input ready);
    modport sink   (input valid, req_type, var_id, var_value, timer_count, output ready);
endinterface

interface tsfs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic [1:0] frame_class;
    logic       frame_end;
    logic       run_last;

    modport source (output valid, tx_byte, frame_class, frame_end, run_last, input ready);
    modport sink   (input valid, tx_byte, frame_class, frame_end, run_last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tsfs_sched.sv =====
// Scheduler: extends the timer count and checks each class period with one shared subtractor.
`timescale 1ns / 1ps
`default_nettype none
module tsfs_sched (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 tick,
    input  wire logic [15:0]          timer_count,
    input  wire tsfs_pkg::word_t      period [tsfs_pkg::NUM_CLASSES],
    input  wire tsfs_pkg::class_mask_t class_enable,
    output tsfs_pkg::frame_req_t      frame_req,
    output logic                      idle
);

    typedef enum logic [1:0] {SC_IDLE, SC_TIME, SC_CHECK} state_t;

    state_t                state_reg;
    logic [15:0]           cnt_reg;
    logic [15:0]           prev_reg;
    tsfs_pkg::word_t       time_high_reg;
    tsfs_pkg::word_t       now_reg;
    tsfs_pkg::word_t       last_send_reg [tsfs_pkg::NUM_CLASSES];
    tsfs_pkg::class_t      cls_reg;
    tsfs_pkg::class_mask_t mask_reg;

    tsfs_pkg::word_t       elapsed;
    logic                  hit;
    tsfs_pkg::class_mask_t mask_cur;

    always_comb
    begin
        elapsed           = now_reg - last_send_reg[cls_reg];
        hit               = (elapsed >= period[cls_reg]);
        mask_cur          = mask_reg;
        mask_cur[cls_reg] = hit & class_enable[cls_reg];
    end

    assign frame_req.start = (state_reg == SC_CHECK) && (cls_reg == tsfs_pkg::CLASS_VFAST);
    assign frame_req.mask  = mask_cur;
    assign idle            = (state_reg == SC_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SC_IDLE;
            cnt_reg       <= '0;
            prev_reg      <= '0;
            time_high_reg <= '0;
            now_reg       <= '0;
            for (int i = 0; i < tsfs_pkg::NUM_CLASSES; i++)
            begin
                last_send_reg[i] <= '0;
            end
            cls_reg  <= tsfs_pkg::CLASS_SLOW;
            mask_reg <= '0;
        end
        else
        begin
            case (state_reg)
                SC_IDLE:
                begin
                    if (tick)
                    begin
                        cnt_reg  <= timer_count;
                        prev_reg <= timer_count;
                        if (timer_count < prev_reg)
                        begin
                            time_high_reg <= time_high_reg + tsfs_pkg::WRAP_STEP;
                        end
                        state_reg <= SC_TIME;
                    end
                end
                SC_TIME:
                begin
                    now_reg   <= time_high_reg + 32'(cnt_reg);
                    cls_reg   <= tsfs_pkg::CLASS_SLOW;
                    mask_reg  <= '0;
                    state_reg <= SC_CHECK;
                end
                SC_CHECK:
                begin
                    if (hit)
                    begin
                        last_send_reg[cls_reg] <= now_reg;
                    end
                    mask_reg <= mask_cur;
                    if (cls_reg == tsfs_pkg::CLASS_VFAST)
                    begin
                        state_reg <= SC_IDLE;
                    end
                    else
                    begin
                        cls_reg <= cls_reg + 2'd1;
                    end
                end
                default:
                begin
                    state_reg <= SC_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tsfs_framer.sv =====
// Framer: sequences the bytes of the due frames into a registered output stage.
`timescale 1ns / 1ps
`default_nettype none
module tsfs_framer (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tsfs_pkg::frame_req_t  frame_req,
    input  wire tsfs_pkg::slot_mask_t  slot_occupied,
    input  wire tsfs_pkg::word_t       rd_value,
    output tsfs_pkg::slot_idx_t        rd_idx,
    output logic                       idle,
    tsfs_out_if.source                 tx
);

    typedef enum logic [2:0] {FR_IDLE, FR_SOF, FR_LEN, FR_ID, FR_DATA, FR_EOF} state_t;

    state_t                state_reg;
    tsfs_pkg::class_t      cls_reg;
    tsfs_pkg::class_mask_t pend_cls_reg;
    tsfs_pkg::slot_mask_t  pend_slot_reg;
    tsfs_pkg::slot_idx_t   slot_reg;
    logic [tsfs_pkg::KW-1:0] k_reg;

    logic       out_valid_reg;
    logic [7:0] byte_reg;
    tsfs_pkg::class_t out_cls_reg;
    logic       end_reg;
    logic       last_reg;

    logic                  load;
    tsfs_pkg::class_t      req_first;
    tsfs_pkg::class_t      pend_first;
    tsfs_pkg::slot_idx_t   slot_first;
    tsfs_pkg::word_t       shifted;

    assign load       = !out_valid_reg || tx.ready;
    assign req_first  = tsfs_pkg::first_class(frame_req.mask);
    assign pend_first = tsfs_pkg::first_class(pend_cls_reg);
    assign slot_first = tsfs_pkg::first_slot(pend_slot_reg);
    assign shifted    = rd_value >> {k_reg, 3'b000};

    assign rd_idx         = slot_reg;
    assign idle           = (state_reg == FR_IDLE);
    assign tx.valid       = out_valid_reg;
    assign tx.tx_byte     = byte_reg;
    assign tx.frame_class = out_cls_reg;
    assign tx.frame_end   = end_reg;
    assign tx.run_last    = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FR_IDLE;
            out_valid_reg <= 1'b0;
            cls_reg       <= tsfs_pkg::CLASS_SLOW;
            pend_cls_reg  <= '0;
            pend_slot_reg <= '0;
            slot_reg      <= '0;
            k_reg         <= '0;
            byte_reg      <= '0;
            out_cls_reg   <= tsfs_pkg::CLASS_SLOW;
            end_reg       <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                FR_IDLE:
                begin
                    if (tx.ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (frame_req.start && (frame_req.mask != '0))
                    begin
                        cls_reg      <= req_first;
                        pend_cls_reg <= frame_req.mask
                                        & ~(tsfs_pkg::NUM_CLASSES'(1) << req_first);
                        state_reg    <= FR_SOF;
                    end
                end
                FR_SOF:
                begin
                    if (load)
                    begin
                        out_valid_reg <= 1'b1;
                        byte_reg      <= tsfs_pkg::SOF_BYTE;
                        out_cls_reg   <= cls_reg;
                        end_reg       <= 1'b0;
                        last_reg      <= 1'b0;
                        pend_slot_reg <= slot_occupied & tsfs_pkg::class_members(cls_reg);
                        state_reg     <= FR_LEN;
                    end
                end
                FR_LEN:
                begin
                    if (load)
                    begin
                        out_valid_reg <= 1'b1;
                        byte_reg      <= tsfs_pkg::len_byte(pend_slot_reg);
                        out_cls_reg   <= cls_reg;
                        end_reg       <= 1'b0;
                        last_reg      <= 1'b0;
                        state_reg     <= (pend_slot_reg != '0) ? FR_ID : FR_EOF;
                    end
                end
                FR_ID:
                begin
                    if (load)
                    begin
                        out_valid_reg <= 1'b1;
                        byte_reg      <= 8'(slot_first);
                        out_cls_reg   <= cls_reg;
                        end_reg       <= 1'b0;
                        last_reg      <= 1'b0;
                        slot_reg      <= slot_first;
                        pend_slot_reg <= pend_slot_reg
                                         & ~(tsfs_pkg::NUM_SLOTS'(1) << slot_first);
                        k_reg         <= '0;
                        state_reg     <= FR_DATA;
                    end
                end
                FR_DATA:
                begin
                    if (load)
                    begin
                        out_valid_reg <= 1'b1;
                        byte_reg      <= shifted[7:0];
                        out_cls_reg   <= cls_reg;
                        end_reg       <= 1'b0;
                        last_reg      <= 1'b0;
                        if (k_reg == tsfs_pkg::KW'(tsfs_pkg::VALUE_BYTES - 1))
                        begin
                            state_reg <= (pend_slot_reg != '0) ? FR_ID : FR_EOF;
                        end
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                FR_EOF:
                begin
                    if (load)
                    begin
                        out_valid_reg <= 1'b1;
                        byte_reg      <= tsfs_pkg::EOF_BYTE;
                        out_cls_reg   <= cls_reg;
                        end_reg       <= 1'b1;
                        last_reg      <= (pend_cls_reg == '0);
                        if (pend_cls_reg == '0)
                        begin
                            state_reg <= FR_IDLE;
                        end
                        else
                        begin
                            cls_reg      <= pend_first;
                            pend_cls_reg <= pend_cls_reg
                                            & ~(tsfs_pkg::NUM_CLASSES'(1) << pend_first);
                            state_reg    <= FR_SOF;
                        end
                    end
                end
                default:
                begin
                    out_valid_reg <= 1'b0;
                    state_reg     <= FR_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/telemetry_slot_framer_scheduler_top.sv =====
// Top level: telemetry slot store, configuration registers, scheduler and framer.
//
// Usage:
//   req  : one beat is either a store (req_type 0: var_id, var_value) or a
//          timer tick (req_type 1: timer_count). Stores to ids 0..4 update the
//          slot at once; other ids are dropped.
//   tx   : frame bytes, one beat per byte, each tagged with its class;
//          frame_end marks the 0x55 trailer, run_last the final byte of a tick.
//   cfg  : cfg_we/cfg_index/cfg_data write the three periods and the class
//          enable mask; write only while the block is idle.
// Sequence: a tick first extends time, then runs the period checks of the
//   three classes (one class per cycle through a single subtract/compare);
//   when a class is due, the framer then loads the first byte.
// Throughput: one byte per cycle while tx is ready, and a tick sends up to
//   29 bytes; req.ready stays low until the last byte of the tick is in
//   the output register.
// Stall: a low tx.ready holds the output register and the sequencer.
// Reset: periods and enable take their defaults, all slots empty, time zero.
`timescale 1ns / 1ps
`default_nettype none
module telemetry_slot_framer_scheduler_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    tsfs_in_if.sink                        req,
    tsfs_out_if.source                     tx,
    input  wire logic                      cfg_we,
    input  wire tsfs_pkg::reg_idx_t        cfg_index,
    input  wire tsfs_pkg::word_t           cfg_data
);

    tsfs_pkg::word_t       period_reg [tsfs_pkg::NUM_CLASSES];
    tsfs_pkg::class_mask_t enable_reg;
    tsfs_pkg::word_t       slot_value_reg [tsfs_pkg::NUM_SLOTS];
    tsfs_pkg::slot_mask_t  occupied_reg;

    logic                  sched_idle;
    logic                  framer_idle;
    logic                  accept;
    logic                  store_hit;
    tsfs_pkg::slot_idx_t   store_idx;
    tsfs_pkg::frame_req_t  frame_req;
    tsfs_pkg::slot_idx_t   rd_idx;
    tsfs_pkg::word_t       rd_value;

    assign req.ready = sched_idle && framer_idle;
    assign accept    = req.valid && req.ready;
    assign store_hit = accept && !req.req_type && (req.var_id < 8'(tsfs_pkg::NUM_SLOTS));
    assign store_idx = req.var_id[tsfs_pkg::SLOT_W-1:0];
    assign rd_value  = slot_value_reg[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg[0] <= tsfs_pkg::RST_PERIOD_SLOW;
            period_reg[1] <= tsfs_pkg::RST_PERIOD_FAST;
            period_reg[2] <= tsfs_pkg::RST_PERIOD_VFAST;
            enable_reg    <= tsfs_pkg::RST_CLASS_ENABLE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tsfs_pkg::REG_PERIOD_SLOW:  period_reg[0] <= cfg_data;
                tsfs_pkg::REG_PERIOD_FAST:  period_reg[1] <= cfg_data;
                tsfs_pkg::REG_PERIOD_VFAST: period_reg[2] <= cfg_data;
                tsfs_pkg::REG_CLASS_ENABLE: enable_reg    <= cfg_data[tsfs_pkg::NUM_CLASSES-1:0];
                default:                    enable_reg    <= enable_reg;
            endcase
        end
    end

    // slot values: unoccupied slots are never read
    always_ff @(posedge clk)
    begin
        if (store_hit)
        begin
            slot_value_reg[store_idx] <= req.var_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= '0;
        end
        else if (store_hit && (req.var_id != 8'd0))
        begin
            occupied_reg[store_idx] <= 1'b1;
        end
    end

    tsfs_sched u_sched (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (accept && req.req_type),
        .timer_count  (req.timer_count),
        .period       (period_reg),
        .class_enable (enable_reg),
        .frame_req    (frame_req),
        .idle         (sched_idle)
    );

    tsfs_framer u_framer (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_req     (frame_req),
        .slot_occupied (occupied_reg),
        .rd_value      (rd_value),
        .rd_idx        (rd_idx),
        .idle          (framer_idle),
        .tx            (tx)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/tsfs_checker.sv =====
// Checker: port-level assertions on the framer top, attached by bind.
`timescale 1ns / 1ps
`default_nettype none
module tsfs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       in_req_type,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_end,
    input wire logic       out_last
);

    // a stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)))
        else $error("tx beat dropped or changed while stalled");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_req_type) |=> !in_ready)
        else $error("ready not withdrawn after a tick");

    a_store_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_req_type) |=> in_ready)
        else $error("store held the request channel");

    a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_end) |-> (out_byte == tsfs_pkg::EOF_BYTE))
        else $error("frame end without trailer byte");

    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_last) |-> out_end)
        else $error("run_last on a byte that does not close a frame");

endmodule

bind telemetry_slot_framer_scheduler_top tsfs_checker u_tsfs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .in_req_type (req.req_type),
    .out_valid   (tx.valid),
    .out_ready   (tx.ready),
    .out_byte    (tx.tx_byte),
    .out_end     (tx.frame_end),
    .out_last    (tx.run_last)
);
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for the telemetry slot framer and scheduler: directed and random beats checked against a frame predictor.
module testbench;
    import tsfs_pkg::*;

    localparam logic [7:0] FRAME_START = 8'hAA;
    localparam logic [7:0] FRAME_STOP  = 8'h55;
    localparam word_t      EPOCH_STEP  = 32'h0001_0000;
    localparam int         DICT_IDS    = 5;
    localparam int         IDLE_GUARD  = 12;
    localparam class_t     CLASS_OF_ID [DICT_IDS] =
        '{CLASS_SLOW, CLASS_FAST, CLASS_VFAST, CLASS_VFAST, CLASS_FAST};

    typedef enum logic {REQ_STORE = 1'b0, REQ_TICK = 1'b1} req_kind_t;

    typedef struct {
        req_kind_t   kind;
        logic [7:0]  var_id;
        word_t       var_value;
        logic [15:0] timer_count;
    } request_t;

    typedef struct {
        logic [7:0] tx_byte;
        class_t     frame_class;
        logic       frame_end;
        logic       run_last;
    } frame_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    reg_idx_t cfg_index;
    word_t cfg_data;

    tsfs_in_if  req_ch ();
    tsfs_out_if tx_ch ();

    telemetry_slot_framer_scheduler_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .tx        (tx_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    word_t       slot_val [DICT_IDS];
    logic [DICT_IDS-1:0] slot_used;
    word_t       epoch_high;
    logic [15:0] last_count;
    word_t       sent_at [NUM_CLASSES];
    word_t       period_of [NUM_CLASSES];
    class_mask_t class_on;

    frame_beat_t pending_beats [$];
    int          err_count = 0;
    bit          idling_on = 1'b1;
    logic [15:0] tick_count = 16'd0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        err_count++;
    endtask

    function automatic int idle_len();
        int r;
        if (!idling_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_beat(ref frame_beat_t q [$], input logic [7:0] b,
                                     input class_t c, input logic last_of_frame);
        frame_beat_t fb;
        fb.tx_byte     = b;
        fb.frame_class = c;
        fb.frame_end   = last_of_frame;
        fb.run_last    = 1'b0;
        q.push_back(fb);
    endfunction

    function automatic void frame_for_class(ref frame_beat_t q [$], input class_t c);
        logic [7:0] len;
        len = 8'd0;
        for (int i = 0; i < DICT_IDS; i++)
            if (slot_used[i] && CLASS_OF_ID[i] == c)
                len = len + 8'(1 + VALUE_BYTES);
        add_beat(q, FRAME_START, c, 1'b0);
        add_beat(q, len, c, 1'b0);
        for (int i = 0; i < DICT_IDS; i++) begin
            if (!(slot_used[i] && CLASS_OF_ID[i] == c))
                continue;
            add_beat(q, 8'(i), c, 1'b0);
            for (int k = 0; k < VALUE_BYTES; k++)
                add_beat(q, (k < 4) ? slot_val[i][8*k +: 8] : 8'h00, c, 1'b0);
        end
        add_beat(q, FRAME_STOP, c, 1'b1);
    endfunction

    function automatic void predict_item(input request_t it);
        frame_beat_t tick_beats [$];
        word_t now_us;
        if (it.kind == REQ_STORE) begin
            if (it.var_id < DICT_IDS) begin
                slot_val[it.var_id] = it.var_value;
                if (it.var_id != 8'd0)
                    slot_used[it.var_id] = 1'b1;
            end
            return;
        end
        if (it.timer_count < last_count)
            epoch_high = epoch_high + EPOCH_STEP;
        last_count = it.timer_count;
        now_us = epoch_high + word_t'(it.timer_count);
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (word_t'(now_us - sent_at[c]) >= period_of[c]) begin
                sent_at[c] = now_us;
                if (class_on[c])
                    frame_for_class(tick_beats, class_t'(c));
            end
        end
        if (tick_beats.size() > 0)
            tick_beats[tick_beats.size() - 1].run_last = 1'b1;
        foreach (tick_beats[i])
            pending_beats.push_back(tick_beats[i]);
    endfunction

    task automatic send_item(input request_t it);
        int gap;
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= it.kind;
        req_ch.var_id      <= it.var_id;
        req_ch.var_value   <= it.var_value;
        req_ch.timer_count <= it.timer_count;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        predict_item(it);
        gap = idle_len();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_store(input logic [7:0] id, input word_t value);
        request_t it;
        it.kind        = REQ_STORE;
        it.var_id      = id;
        it.var_value   = value;
        it.timer_count = 16'($urandom);
        send_item(it);
    endtask

    task automatic send_tick(input logic [15:0] cnt);
        request_t it;
        it.kind        = REQ_TICK;
        it.var_id      = 8'($urandom);
        it.var_value   = $urandom;
        it.timer_count = cnt;
        tick_count     = cnt;
        send_item(it);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (IDLE_GUARD) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input word_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PERIOD_SLOW:  period_of[CLASS_SLOW]  = data;
            REG_PERIOD_FAST:  period_of[CLASS_FAST]  = data;
            REG_PERIOD_VFAST: period_of[CLASS_VFAST] = data;
            REG_CLASS_ENABLE: class_on = data[NUM_CLASSES-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_periods(input word_t slow_p, input word_t fast_p, input word_t vfast_p);
        write_reg(REG_PERIOD_SLOW, slow_p);
        write_reg(REG_PERIOD_FAST, fast_p);
        write_reg(REG_PERIOD_VFAST, vfast_p);
    endtask

    // reset defaults: only the very fast class is on; unknown ids and id zero
    task automatic test_defaults();
        send_store(8'd0, 32'hA5A5_A5A5);
        send_store(8'd2, 32'hFFFF_FFFF);
        send_store(8'd3, 32'h0000_0000);
        send_store(8'd5, 32'h1111_1111);
        send_store(8'd255, 32'h2222_2222);
        send_tick(16'd0);
        send_tick(16'd1000);
        send_tick(16'd999);
    endtask

    // zero periods and every class on: longest run of bytes per tick
    task automatic test_full_frames();
        wait_idle();
        write_periods(32'd0, 32'd0, 32'd0);
        write_reg(REG_CLASS_ENABLE, 32'd7);
        send_store(8'd1, 32'h0102_0304);
        send_store(8'd4, 32'h8000_0000);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
    endtask

    // largest periods, disabled classes still tracking time, single classes
    task automatic test_period_extremes();
        wait_idle();
        write_periods(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tick(16'd0);
        send_tick(16'd100);
        wait_idle();
        write_periods(32'd0, 32'd0, 32'd0);
        write_reg(REG_CLASS_ENABLE, 32'd0);
        send_tick(16'd200);
        wait_idle();
        write_reg(REG_CLASS_ENABLE, 32'd1);
        send_tick(16'd300);
        wait_idle();
        write_reg(REG_CLASS_ENABLE, 32'd2);
        send_tick(16'd300);
        send_store(8'd4, 32'h5A5A_5A5A);
        send_tick(16'd301);
    endtask

    function automatic word_t pick_period();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 4000);
        endcase
    endfunction

    task automatic random_item();
        int r;
        logic [7:0] id;
        word_t value;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
            case ($urandom_range(0, 7))
                0: value = 32'd0;
                1: value = 32'hFFFF_FFFF;
                default: value = $urandom;
            endcase
            send_store(id, value);
        end else if (r < 85) begin
            send_tick(tick_count + 16'($urandom_range(0, 1500)));
        end else if (r < 93) begin
            send_tick(16'($urandom_range(0, 65535)));
        end else begin
            send_tick(tick_count - 16'($urandom_range(1, 200)));
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            idling_on = (phase != 0);
            write_periods(pick_period(), pick_period(), pick_period());
            write_reg(REG_CLASS_ENABLE, (phase == 3) ? 32'd7 : $urandom_range(0, 7));
            repeat (25) random_item();
        end
    endtask

    // result side: random stalls, check each beat against the oldest expectation
    initial begin : tx_sink
        frame_beat_t want;
        int stall_left;
        stall_left = 0;
        tx_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && tx_ch.valid === 1'b1 && tx_ch.ready === 1'b1) begin
                if (pending_beats.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat %02h", tx_ch.tx_byte));
                end else begin
                    want = pending_beats.pop_front();
                    if (tx_ch.tx_byte !== want.tx_byte)
                        report_mismatch($sformatf("tx_byte %02h, want %02h",
                                                  tx_ch.tx_byte, want.tx_byte));
                    if (tx_ch.frame_class !== want.frame_class)
                        report_mismatch($sformatf("frame_class %0d, want %0d",
                                                  tx_ch.frame_class, want.frame_class));
                    if (tx_ch.frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end %b, want %b",
                                                  tx_ch.frame_end, want.frame_end));
                    if (tx_ch.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %b, want %b",
                                                  tx_ch.run_last, want.run_last));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                tx_ch.ready <= 1'b0;
            end else begin
                stall_left = idle_len();
                tx_ch.ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_PERIOD_SLOW;
        cfg_data           <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_STORE;
        req_ch.var_id      <= 8'd0;
        req_ch.var_value   <= '0;
        req_ch.timer_count <= 16'd0;
        foreach (slot_val[i])
            slot_val[i] = '0;
        slot_used  = '0;
        epoch_high = '0;
        last_count = 16'd0;
        foreach (sent_at[i])
            sent_at[i] = '0;
        period_of[CLASS_SLOW]  = 32'd100000;
        period_of[CLASS_FAST]  = 32'd10000;
        period_of[CLASS_VFAST] = 32'd1000;
        class_on = 3'd4;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_full_frames();
        test_period_extremes();
        test_random_traffic();
        wait_idle();
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
